// ===== rtl/core/ssrd_pkg.sv =====
// Package of shared codes and types for the sprite scanline run-length decoder.
package ssrd_pkg;

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // Pixel kinds carried on the result channel.
  localparam logic [2:0] KIND_TRANSPARENT = 3'd0;
  localparam logic [2:0] KIND_COLOUR      = 3'd1;
  localparam logic [2:0] KIND_PLAYER      = 3'd2;
  localparam logic [2:0] KIND_SHADOW      = 3'd3;
  localparam logic [2:0] KIND_OUTLINE     = 3'd4;
  localparam logic [2:0] KIND_SHIELD      = 3'd5;

  // Run kinds held between a command byte and its count or colour bytes.
  localparam logic [2:0] RK_LIST     = 3'd0;
  localparam logic [2:0] RK_PLIST    = 3'd1;
  localparam logic [2:0] RK_FILL     = 3'd2;
  localparam logic [2:0] RK_PFILL    = 3'd3;
  localparam logic [2:0] RK_SKIP     = 3'd4;
  localparam logic [2:0] RK_SHADOW   = 3'd5;
  localparam logic [2:0] RK_OCOLOUR  = 3'd6;
  localparam logic [2:0] RK_OSHIELD  = 3'd7;

  // Low two bits of a command byte.
  localparam logic [1:0] LO2_LIST = 2'd0;
  localparam logic [1:0] LO2_SKIP = 2'd1;

  // Low nibble of the extended command codes.
  localparam logic [3:0] LO4_BIG_LIST  = 4'h2;
  localparam logic [3:0] LO4_BIG_SKIP  = 4'h3;
  localparam logic [3:0] LO4_PLIST     = 4'h6;
  localparam logic [3:0] LO4_FILL      = 4'h7;
  localparam logic [3:0] LO4_PFILL     = 4'hA;
  localparam logic [3:0] LO4_SHADOW    = 4'hB;

  // Whole-byte commands.
  localparam logic [7:0] CMD_OSHIELD_RUN  = 8'h7E;
  localparam logic [7:0] CMD_OCOLOUR_RUN  = 8'h5E;
  localparam logic [7:0] CMD_OSHIELD_ONE  = 8'h6E;
  localparam logic [7:0] CMD_OCOLOUR_ONE  = 8'h4E;
  localparam logic [7:0] CMD_END_OF_LINE  = 8'h0F;

  // Line width after reset.
  localparam logic [11:0] WIDTH_RESET = 12'd64;

  // One decoded run as held in the result register.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [11:0] length;
    logic        line_end;
    logic        bad;
  } result_t;

  // Pixel kind for a run that repeats the last colour byte.
  function automatic logic [2:0] repeat_kind(input logic [2:0] rk);
    logic [2:0] k;
    unique case (rk)
      RK_SKIP:    k = KIND_TRANSPARENT;
      RK_SHADOW:  k = KIND_SHADOW;
      RK_OCOLOUR: k = KIND_OUTLINE;
      default:    k = KIND_SHIELD;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/sprite_scanline_rle_decoder_core.sv =====
// Top level of the sprite scanline run-length decoder.
// A request is held in the input register, then its run moves to the result register.
// Throughput: one request per cycle when not stalled; each byte is one decision
// on registered state. Input and result registers are parted, so input is taken while a
// finished run waits, and stall on the input rises only when both are full.
// Reset (rst, synchronous, active high) closes the line, clears the decode state
// and sets the line width to 64; the block is ready as soon as reset is released.
module sprite_scanline_rle_decoder_core #(
  parameter int COUNT_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [11:0] left_margin,
  input  logic        blank_line,
  input  logic [7:0]  stream_byte,
  // Run channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  pixel_kind,
  output logic [7:0]  pixel_value,
  output logic [11:0] run_length,
  output logic        line_end,
  output logic        bad_command,
  // Line width register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);
  import ssrd_pkg::*;

  localparam int CntW     = (COUNT_BITS > 12) ? COUNT_BITS : 12;
  localparam int CountMax = (1 << COUNT_BITS) - 1;

  // Decode phases.
  localparam logic [1:0] PH_CMD     = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_LIST    = 2'd2;
  localparam logic [1:0] PH_FILLCOL = 2'd3;

  // Input register.
  logic        s_valid;
  logic        s_mode;
  logic [11:0] s_margin;
  logic        s_blank;
  logic [7:0]  s_byte;

  // Decode state.
  logic [11:0]           line_width;
  logic                  line_open, line_open_next;
  logic [1:0]            phase, phase_next;
  logic [2:0]            run_kind, run_kind_next;
  logic [3:0]            count_high, count_high_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic [11:0]           position, position_next;
  logic [7:0]            last_colour, last_colour_next;

  // Result register.
  result_t result;

  // Handshake control.
  logic take_in;
  logic advance;
  logic process;

  // Decode results.
  logic            emit_req;
  logic [2:0]      e_kind;
  logic [7:0]      e_value;
  logic [CntW-1:0] e_count;
  logic            bad;
  logic [11:0]     base_pos;
  logic [11:0]     room;
  logic [11:0]     len;
  logic [12:0]     pos_sum;
  logic            run_end;
  logic            has_result;
  logic [11:0]     cnt_raw;
  logic [CntW-1:0] cnt_ext;
  logic [CntW-1:0] cnt_sat;
  logic [COUNT_BITS-1:0] rem_dec;

  // The result register frees when empty or when its run is taken.
  assign advance   = !out_valid || !out_stall;
  assign process   = s_valid && advance;
  assign in_stall  = s_valid && !advance;
  assign take_in   = in_valid && !in_stall;
  assign cfg_ready = !s_valid;

  // Count byte joined with the high nibble, saturated to the counter.
  assign cnt_raw = {count_high, s_byte};
  assign cnt_ext = CntW'(cnt_raw);
  assign cnt_sat = (cnt_ext > CntW'(CountMax)) ? CntW'(CountMax) : cnt_ext;
  assign rem_dec = remaining - {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // Byte and start decode.
  always_comb begin
    line_open_next   = line_open;
    phase_next       = phase;
    run_kind_next    = run_kind;
    count_high_next  = count_high;
    remaining_next   = remaining;
    last_colour_next = last_colour;
    emit_req         = 1'b0;
    e_kind           = KIND_TRANSPARENT;
    e_value          = 8'd0;
    e_count          = '0;
    bad              = 1'b0;
    base_pos         = position;
    if (s_mode == MODE_START) begin
      phase_next       = PH_CMD;
      run_kind_next    = RK_LIST;
      count_high_next  = 4'd0;
      remaining_next   = '0;
      last_colour_next = 8'd0;
      line_open_next   = 1'b1;
      base_pos         = 12'd0;
      emit_req         = 1'b1;
      e_count          = CntW'(s_blank ? line_width : s_margin);
    end else if (!line_open) begin
      // Bytes outside a line are dropped.
    end else if (position >= line_width) begin
      line_open_next = 1'b0;
      phase_next     = PH_CMD;
    end else begin
      unique case (phase)
        PH_COUNT: begin
          count_high_next = 4'd0;
          phase_next      = PH_CMD;
          if (run_kind == RK_LIST || run_kind == RK_PLIST) begin
            if (cnt_sat != '0) begin
              remaining_next = COUNT_BITS'(cnt_sat);
              phase_next     = PH_LIST;
            end
          end else if (run_kind == RK_FILL || run_kind == RK_PFILL) begin
            remaining_next = COUNT_BITS'(cnt_sat);
            phase_next     = PH_FILLCOL;
          end else if (cnt_sat != '0) begin
            emit_req = 1'b1;
            e_kind   = repeat_kind(run_kind);
            e_value  = last_colour;
            e_count  = cnt_sat;
          end
        end
        PH_LIST: begin
          last_colour_next = s_byte;
          remaining_next   = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_CMD;
          end
          emit_req = 1'b1;
          e_kind   = (run_kind == RK_PLIST) ? KIND_PLAYER : KIND_COLOUR;
          e_value  = s_byte;
          e_count  = CntW'(1);
        end
        PH_FILLCOL: begin
          last_colour_next = s_byte;
          phase_next       = PH_CMD;
          remaining_next   = '0;
          if (remaining != '0) begin
            emit_req = 1'b1;
            e_kind   = (run_kind == RK_PFILL) ? KIND_PLAYER : KIND_COLOUR;
            e_value  = s_byte;
            e_count  = CntW'(remaining);
          end
        end
        PH_CMD: begin
          count_high_next = 4'd0;
          unique case (s_byte[1:0])
            LO2_LIST: begin
              if (s_byte[7:2] != 6'd0) begin
                run_kind_next  = RK_LIST;
                remaining_next = COUNT_BITS'(s_byte[7:2]);
                phase_next     = PH_LIST;
              end
            end
            LO2_SKIP: begin
              if (s_byte[7:2] == 6'd0) begin
                run_kind_next = RK_SKIP;
                phase_next    = PH_COUNT;
              end else begin
                emit_req = 1'b1;
                e_kind   = KIND_TRANSPARENT;
                e_value  = last_colour;
                e_count  = CntW'(s_byte[7:2]);
              end
            end
            default: begin
              priority if (s_byte[3:0] == LO4_BIG_LIST) begin
                run_kind_next   = RK_LIST;
                count_high_next = s_byte[7:4];
                phase_next      = PH_COUNT;
              end else if (s_byte[3:0] == LO4_BIG_SKIP) begin
                run_kind_next   = RK_SKIP;
                count_high_next = s_byte[7:4];
                phase_next      = PH_COUNT;
              end else if (s_byte[3:0] == LO4_PLIST) begin
                run_kind_next = RK_PLIST;
                if (s_byte[7:4] == 4'd0) begin
                  phase_next = PH_COUNT;
                end else begin
                  remaining_next = COUNT_BITS'(s_byte[7:4]);
                  phase_next     = PH_LIST;
                end
              end else if (s_byte[3:0] == LO4_FILL || s_byte[3:0] == LO4_PFILL) begin
                run_kind_next = (s_byte[3:0] == LO4_FILL) ? RK_FILL : RK_PFILL;
                if (s_byte[7:4] == 4'd0) begin
                  phase_next = PH_COUNT;
                end else begin
                  remaining_next = COUNT_BITS'(s_byte[7:4]);
                  phase_next     = PH_FILLCOL;
                end
              end else if (s_byte[3:0] == LO4_SHADOW) begin
                if (s_byte[7:4] == 4'd0) begin
                  run_kind_next = RK_SHADOW;
                  phase_next    = PH_COUNT;
                end else begin
                  emit_req = 1'b1;
                  e_kind   = KIND_SHADOW;
                  e_value  = last_colour;
                  e_count  = CntW'(s_byte[7:4]);
                end
              end else if (s_byte == CMD_OSHIELD_RUN) begin
                run_kind_next = RK_OSHIELD;
                phase_next    = PH_COUNT;
              end else if (s_byte == CMD_OCOLOUR_RUN) begin
                run_kind_next = RK_OCOLOUR;
                phase_next    = PH_COUNT;
              end else if (s_byte == CMD_OSHIELD_ONE) begin
                emit_req = 1'b1;
                e_kind   = KIND_SHIELD;
                e_value  = last_colour;
                e_count  = CntW'(1);
              end else if (s_byte == CMD_OCOLOUR_ONE) begin
                emit_req = 1'b1;
                e_kind   = KIND_OUTLINE;
                e_value  = last_colour;
                e_count  = CntW'(1);
              end else if (s_byte == CMD_END_OF_LINE) begin
                last_colour_next = 8'd0;
                emit_req         = 1'b1;
                e_kind           = KIND_TRANSPARENT;
                e_value          = 8'd0;
                e_count          = CntW'(line_width);
              end else begin
                bad = 1'b1;
              end
            end
          endcase
        end
      endcase
    end

    // Clip the run to the rest of the line and advance the position.
    room    = (line_width > base_pos) ? (line_width - base_pos) : 12'd0;
    len     = (e_count < CntW'(room)) ? e_count[11:0] : room;
    pos_sum = {1'b0, base_pos} + {1'b0, len};
    run_end = (pos_sum[11:0] >= line_width);
    position_next = emit_req ? pos_sum[11:0] : position;
    if (emit_req && run_end) begin
      line_open_next = 1'b0;
      phase_next     = PH_CMD;
    end
    has_result = emit_req ? (len != 12'd0 || run_end) : bad;
  end

  // Input register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take_in) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
    if (take_in) begin
      s_mode   <= mode;
      s_margin <= left_margin;
      s_blank  <= blank_line;
      s_byte   <= stream_byte;
    end
  end

  // Decode state and line width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= WIDTH_RESET;
      line_open   <= 1'b0;
      phase       <= PH_CMD;
      run_kind    <= RK_LIST;
      count_high  <= 4'd0;
      remaining   <= '0;
      position    <= 12'd0;
      last_colour <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width <= cfg_data;
      end
      if (process) begin
        line_open   <= line_open_next;
        phase       <= phase_next;
        run_kind    <= run_kind_next;
        count_high  <= count_high_next;
        remaining   <= remaining_next;
        position    <= position_next;
        last_colour <= last_colour_next;
      end
    end
  end

  // Result register: loads on each decoded item; out_valid rises only if it gives a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= has_result;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
    if (process) begin
      result.kind     <= e_kind;
      result.value    <= e_value;
      result.length   <= emit_req ? len : 12'd0;
      result.line_end <= emit_req && run_end;
      result.bad      <= bad;
    end
  end

  assign pixel_kind  = result.kind;
  assign pixel_value = result.value;
  assign run_length  = result.length;
  assign line_end    = result.line_end;
  assign bad_command = result.bad;

  // A run that completes the line leaves it closed.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    process && has_result && emit_req && run_end |=> !line_open)
    else $error("line stayed open after its last run");

  // A flagged command carries no pixels and does not end the line.
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_command |-> run_length == 12'd0 && !line_end)
    else $error("bad command result carries a run");

  // Input is held back only while both registers are occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A start request always returns the decoder to command phase.
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    process && s_mode == MODE_START |=> phase == PH_CMD)
    else $error("start request left a pending phase");

endmodule
